### rtl/core/mspm_pkg.sv
// Shared types and constants for the masked scope path matcher.
// No dependencies; compiled before the channel interfaces and the core.
package mspm_pkg;

    localparam int SCOPE_W    = 64;  // width of the scope and mask fields on the ports
    localparam int ATOM_W     = 4;   // width of an atom count
    localparam int SLOT_W     = 5;
    localparam int SEL_LEN_W  = 5;
    localparam int PATH_LEN_W = 6;
    localparam int SCORE_W    = 32;  // UQ16.16 score
    localparam int FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        REQ_LOAD_SEL  = 2'd0,
        REQ_LOAD_PATH = 2'd1,
        REQ_START     = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### rtl/core/mspm_req_if.sv
// Request channel of the masked scope path matcher: valid/ready plus the request fields.
// Depends on mspm_pkg for the field widths.
interface mspm_req_if
    import mspm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [SLOT_W-1:0]     slot;
    logic [SCOPE_W-1:0]    scope_bits;
    logic [SCOPE_W-1:0]    scope_mask;
    logic [ATOM_W-1:0]     atom_count;
    logic [SEL_LEN_W-1:0]  sel_length;
    logic [PATH_LEN_W-1:0] path_length;
    logic                  anchor_start;
    logic                  anchor_end;

    modport source (
        output valid, req_type, slot, scope_bits, scope_mask, atom_count,
               sel_length, path_length, anchor_start, anchor_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot, scope_bits, scope_mask, atom_count,
               sel_length, path_length, anchor_start, anchor_end,
        output ready
    );
endinterface

### rtl/core/mspm_rsp_if.sv
// Result channel of the masked scope path matcher: valid/ready plus matched and score.
// Depends on mspm_pkg for the score width.
interface mspm_rsp_if
    import mspm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               matched;
    logic [SCORE_W-1:0] score;

    modport source (
        output valid, matched, score,
        input  ready
    );

    modport sink (
        input  valid, matched, score,
        output ready
    );
endinterface

### rtl/core/masked_scope_path_matcher_core.sv
// Top level of the masked scope path matcher: entry stores, walk sequencer and score unit.
// Depends on mspm_pkg, mspm_req_if and mspm_rsp_if.
//
// Usage: requests arrive on the req channel. A selector load (scope bits, mask, atom
// count) or a path load (scope bits, atom count) writes one entry of its store in the
// cycle of the transfer and gives no result; a load whose slot lies beyond the store is
// dropped, as is the unused request code. A start request walks the path from the front
// and the selector from the back and returns one result (matched, UQ16.16 score) on the
// rsp channel.
// Sequence: a start passes through a fetch state, then the walk steps (at most the path
// length after saturation, each one masked compare against the synchronous stores), then
// a drain state for the score adder and a done state that writes the output register,
// after which the next request is taken; an empty selector or a selector longer than the
// path goes straight to the done state. Each walk step uses the registered read port of
// the stores, with the next selector address chosen from the compare.
// The output register holds a finished result until the receiver takes it; loads are
// still taken meanwhile, and a following start walks and then waits in its last state
// until the output register is free. A stalled receiver therefore never loses a result.
// Reset clears the control state and the output valid; the store contents are undefined
// until loaded.
module masked_scope_path_matcher_core
    import mspm_pkg::*;
#(
    parameter int SEL_MAX     = 16,
    parameter int PATH_MAX    = 32,
    parameter int SCOPE_WIDTH = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    mspm_req_if.sink   req,
    mspm_rsp_if.source rsp
);

    localparam int SW    = $clog2(SEL_MAX + 1);              // selector count
    localparam int PW    = $clog2(PATH_MAX + 1);             // path count
    localparam int SAW   = (SEL_MAX > 1) ? $clog2(SEL_MAX) : 1;
    localparam int PAW   = (PATH_MAX > 1) ? $clog2(PATH_MAX) : 1;
    localparam int POW_W = $clog2(15 * PATH_MAX + 32);       // running power plus headroom

    // Entry stores: synchronous memories, one read port each with a registered output.
    logic [SCOPE_WIDTH-1:0] sel_bits_mem  [SEL_MAX];
    logic [SCOPE_WIDTH-1:0] sel_mask_mem  [SEL_MAX];
    logic [ATOM_W-1:0]      sel_atoms_mem [SEL_MAX];
    logic [SCOPE_WIDTH-1:0] path_bits_mem [PATH_MAX];
    logic [ATOM_W-1:0]      path_atoms_mem[PATH_MAX];

    logic [SCOPE_WIDTH-1:0] sel_rd_bits;
    logic [SCOPE_WIDTH-1:0] sel_rd_mask;
    logic [ATOM_W-1:0]      sel_rd_atoms;
    logic [SCOPE_WIDTH-1:0] path_rd_bits;
    logic [ATOM_W-1:0]      path_rd_atoms;

    state_t state_reg, state_next;

    logic [SW-1:0]      j_reg, j_next;          // selector entries still to match
    logic [PW-1:0]      i_reg, i_next;          // path entries still to visit
    logic [PW-1:0]      p_reg, p_next;          // current path index
    logic [SW-1:0]      sel_len_reg, sel_len_next;
    logic               bol_reg, bol_next;
    logic               eol_reg, eol_next;      // end anchor still pending on first step
    logic               ok_reg, ok_next;        // outcome of the walk
    logic [POW_W-1:0]   power_reg, power_next;
    logic [SCORE_W-1:0] acc_reg, acc_next;

    // Score stage, registered from the compare and used in the cycle after it.
    logic               sc_hit_reg, sc_hit_next;
    logic [POW_W-1:0]   sc_power_reg, sc_power_next;
    logic [ATOM_W-1:0]  sc_atoms_reg, sc_atoms_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_matched_reg, rsp_matched_next;
    logic [SCORE_W-1:0] rsp_score_reg, rsp_score_next;

    logic            in_xfer;
    logic            rd_en;
    logic [SAW-1:0]  sel_raddr;
    logic [PAW-1:0]  path_raddr;
    logic            out_free;

    logic [SW-1:0]   start_sel_len;
    logic [PW-1:0]   start_path_len;
    logic            start_empty;
    logic            start_short;

    logic            hit;
    logic [SW-1:0]   j_step;
    logic [PW-1:0]   i_step;
    logic            eol_fail;
    logic            bol_fail;
    logic            walk_cont;
    logic            step_end;
    logic [POW_W-1:0] power_step;

    logic [POW_W-1:0]   n_plus_frac;
    logic [4:0]         hi_exp;
    logic [4:0]         lo_exp;
    logic [SCORE_W-1:0] term;
    logic [SCORE_W:0]   acc_sum;

    assign in_xfer  = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // Lengths saturate to the store depths.
    assign start_sel_len  = (32'(req.sel_length) > SEL_MAX) ? SW'(SEL_MAX)
                                                             : SW'(req.sel_length);
    assign start_path_len = (32'(req.path_length) > PATH_MAX) ? PW'(PATH_MAX)
                                                               : PW'(req.path_length);
    assign start_empty = (start_sel_len == '0);
    assign start_short = (32'(start_sel_len) > 32'(start_path_len));

    // One walk step on the entries read in the previous cycle.
    assign hit        = (sel_rd_bits == (path_rd_bits & sel_rd_mask));
    assign j_step     = j_reg - SW'(hit);
    assign i_step     = i_reg - PW'(1);
    assign eol_fail   = eol_reg && (j_step == sel_len_reg);
    assign bol_fail   = bol_reg && (j_step == '0) && (i_step != '0);
    assign walk_cont  = (j_step != '0) && (32'(j_step) <= 32'(i_step));
    assign step_end   = eol_fail || bol_fail || !walk_cont;
    assign power_step = power_reg + POW_W'(path_rd_atoms);

    // Store writes and reads.
    always_ff @(posedge clk)
    begin
        if (in_xfer && (req.req_type == REQ_LOAD_SEL) && (32'(req.slot) < SEL_MAX))
        begin
            sel_bits_mem[SAW'(req.slot)]  <= req.scope_bits[SCOPE_WIDTH-1:0];
            sel_mask_mem[SAW'(req.slot)]  <= req.scope_mask[SCOPE_WIDTH-1:0];
            sel_atoms_mem[SAW'(req.slot)] <= req.atom_count;
        end
        if (in_xfer && (req.req_type == REQ_LOAD_PATH) && (32'(req.slot) < PATH_MAX))
        begin
            path_bits_mem[PAW'(req.slot)]  <= req.scope_bits[SCOPE_WIDTH-1:0];
            path_atoms_mem[PAW'(req.slot)] <= req.atom_count;
        end
        if (rd_en)
        begin
            sel_rd_bits   <= sel_bits_mem[sel_raddr];
            sel_rd_mask   <= sel_mask_mem[sel_raddr];
            sel_rd_atoms  <= sel_atoms_mem[sel_raddr];
            path_rd_bits  <= path_bits_mem[path_raddr];
            path_rd_atoms <= path_atoms_mem[path_raddr];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req.req_type == REQ_START))
                begin
                    if (start_empty || start_short)
                        state_next = ST_DONE;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_STEP;
            ST_STEP:
            begin
                if (step_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: request ready and store read port.
    always_comb
    begin
        req.ready  = 1'b0;
        rd_en      = 1'b0;
        sel_raddr  = SAW'(j_reg - SW'(1));
        path_raddr = PAW'(p_reg);
        case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_FETCH: rd_en = 1'b1;
            ST_STEP:
            begin
                rd_en      = 1'b1;
                sel_raddr  = SAW'(j_step - SW'(1));
                path_raddr = PAW'(p_reg + PW'(1));
            end
            ST_DRAIN: rd_en = 1'b0;
            ST_DONE:  rd_en = 1'b0;
            default:  rd_en = 1'b0;
        endcase
    end

    // Score term: sum over k < n of 2^(k - power + 16), dropping negative exponents,
    // which is 2^(n + 16 - power) - 2^max(16 - power, 0) when any term survives.
    always_comb
    begin
        n_plus_frac = POW_W'(sc_atoms_reg) + POW_W'(FRAC_BITS);
        hi_exp      = 5'(n_plus_frac - sc_power_reg);
        lo_exp      = (sc_power_reg < POW_W'(FRAC_BITS))
                      ? 5'(POW_W'(FRAC_BITS) - sc_power_reg) : 5'd0;
        term        = '0;
        if (sc_hit_reg && (sc_atoms_reg != '0) && (sc_power_reg < n_plus_frac))
            term = (SCORE_W'(1) << hi_exp) - (SCORE_W'(1) << lo_exp);
        acc_sum = {1'b0, acc_reg} + {1'b0, term};
    end

    // Datapath next values.
    always_comb
    begin
        j_next           = j_reg;
        i_next           = i_reg;
        p_next           = p_reg;
        sel_len_next     = sel_len_reg;
        bol_next         = bol_reg;
        eol_next         = eol_reg;
        ok_next          = ok_reg;
        power_next       = power_reg;
        acc_next         = acc_sum[SCORE_W] ? '1 : acc_sum[SCORE_W-1:0];
        sc_hit_next      = 1'b0;
        sc_power_next    = sc_power_reg;
        sc_atoms_next    = sc_atoms_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_matched_next = rsp_matched_reg;
        rsp_score_next   = rsp_score_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req.req_type == REQ_START))
                begin
                    j_next       = start_sel_len;
                    i_next       = start_path_len;
                    p_next       = '0;
                    sel_len_next = start_sel_len;
                    bol_next     = req.anchor_start;
                    eol_next     = req.anchor_end;
                    ok_next      = start_empty;
                    power_next   = '0;
                    acc_next     = '0;
                end
            end
            ST_FETCH: ok_next = 1'b0;
            ST_STEP:
            begin
                j_next        = j_step;
                i_next        = i_step;
                p_next        = p_reg + PW'(1);
                eol_next      = 1'b0;
                power_next    = power_step;
                sc_hit_next   = hit;
                sc_power_next = power_step;
                sc_atoms_next = sel_rd_atoms;
                ok_next       = !eol_fail && !bol_fail && (j_step == '0);
            end
            ST_DRAIN: ok_next = ok_reg;
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_matched_next = ok_reg;
                    rsp_score_next   = ok_reg ? acc_reg : '0;
                end
            end
            default: ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sc_hit_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sc_hit_reg    <= sc_hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg           <= j_next;
        i_reg           <= i_next;
        p_reg           <= p_next;
        sel_len_reg     <= sel_len_next;
        bol_reg         <= bol_next;
        eol_reg         <= eol_next;
        ok_reg          <= ok_next;
        power_reg       <= power_next;
        acc_reg         <= acc_next;
        sc_power_reg    <= sc_power_next;
        sc_atoms_reg    <= sc_atoms_next;
        rsp_matched_reg <= rsp_matched_next;
        rsp_score_reg   <= rsp_score_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.matched = rsp_matched_reg;
    assign rsp.score   = rsp_score_reg;

`ifndef SYNTHESIS
    // While stepping, selectors remain and never outnumber the unvisited path entries.
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> ((j_reg != '0) && (32'(j_reg) <= 32'(i_reg))))
        else $error("walk counters out of bounds");

    // A start transfer always launches the sequencer.
    a_start_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (req.req_type == REQ_START)) |=> (state_reg != ST_IDLE))
        else $error("start transfer did not leave idle");

    // A new result appears only from the final state of a walk.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    // A failed match never carries a score.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_matched_reg) |-> (rsp_score_reg == '0))
        else $error("unmatched result with non-zero score");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for masked_scope_path_matcher_core: drives load and start transfers
// with random idling on both channels and checks every result against an internal predictor.
// Depends on mspm_pkg, mspm_req_if, mspm_rsp_if and the core itself.
module testbench;
    import mspm_pkg::*;

    localparam int unsigned SEL_SLOTS  = 16;
    localparam int unsigned PATH_SLOTS = 32;
    localparam int          SEL_IW     = $clog2(SEL_SLOTS);
    localparam int          PATH_IW    = $clog2(PATH_SLOTS);
    localparam longint unsigned SCORE_CEIL = 64'hFFFF_FFFF;

    typedef struct {
        req_type_t             kind;
        logic [SLOT_W-1:0]     slot;
        logic [SCOPE_W-1:0]    bits;
        logic [SCOPE_W-1:0]    mask;
        logic [ATOM_W-1:0]     atoms;
        logic [SEL_LEN_W-1:0]  sel_len;
        logic [PATH_LEN_W-1:0] path_len;
        logic                  anchor_start;
        logic                  anchor_end;
    } mspm_item_t;

    typedef struct packed {
        logic               matched;
        logic [SCORE_W-1:0] score;
    } match_result_t;

    logic clk;
    logic rst_n;

    mspm_req_if req_ch ();
    mspm_rsp_if rsp_ch ();

    masked_scope_path_matcher_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Private image of the entry stores, updated as each load transfer completes.
    logic [SCOPE_W-1:0] sel_bits_img  [SEL_SLOTS];
    logic [SCOPE_W-1:0] sel_mask_img  [SEL_SLOTS];
    logic [ATOM_W-1:0]  sel_atoms_img [SEL_SLOTS];
    logic [SCOPE_W-1:0] path_bits_img [PATH_SLOTS];
    logic [ATOM_W-1:0]  path_atoms_img[PATH_SLOTS];

    match_result_t pending_matches[$];
    int unsigned   accepted_items = 0;
    int unsigned   fail_count     = 0;
    bit            source_steady  = 1'b0;
    bit            sink_steady    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("masked_scope_path_matcher_core verification failed");
        $finish;
    end

    function automatic logic [SCOPE_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Small atom counts keep the running power low, so that scores stay visible.
    function automatic logic [ATOM_W-1:0] pick_atoms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return ATOM_W'($urandom_range(0, 2));
        if (r < 85)
            return ATOM_W'($urandom_range(3, 6));
        return ATOM_W'($urandom_range(7, 15));
    endfunction

    function automatic logic [SCOPE_W-1:0] pick_mask();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return rand_word();
        if (r < 65)
            return rand_word() & rand_word() & rand_word();
        if (r < 75)
            return '0;
        if (r < 85)
            return '1;
        return {SCOPE_W{1'b1}} >> $urandom_range(1, SCOPE_W - 1);
    endfunction

    // Fields that the request kind does not use still carry random values.
    function automatic mspm_item_t blank_item(input req_type_t kind);
        mspm_item_t it;
        it.kind         = kind;
        it.slot         = SLOT_W'($urandom_range(0, 31));
        it.bits         = rand_word();
        it.mask         = rand_word();
        it.atoms        = ATOM_W'($urandom_range(0, 15));
        it.sel_len      = SEL_LEN_W'($urandom_range(0, 31));
        it.path_len     = PATH_LEN_W'($urandom_range(0, 63));
        it.anchor_start = 1'($urandom_range(0, 1));
        it.anchor_end   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic mspm_item_t make_sel_load(input int unsigned slot,
                                                 input logic [SCOPE_W-1:0] bits,
                                                 input logic [SCOPE_W-1:0] mask,
                                                 input logic [ATOM_W-1:0] atoms);
        mspm_item_t it;
        it       = blank_item(REQ_LOAD_SEL);
        it.slot  = SLOT_W'(slot);
        it.bits  = bits;
        it.mask  = mask;
        it.atoms = atoms;
        return it;
    endfunction

    function automatic mspm_item_t make_path_load(input int unsigned slot,
                                                  input logic [SCOPE_W-1:0] bits,
                                                  input logic [ATOM_W-1:0] atoms);
        mspm_item_t it;
        it       = blank_item(REQ_LOAD_PATH);
        it.slot  = SLOT_W'(slot);
        it.bits  = bits;
        it.atoms = atoms;
        return it;
    endfunction

    function automatic mspm_item_t make_start(input int unsigned sel_len,
                                              input int unsigned path_len,
                                              input logic bol, input logic eol);
        mspm_item_t it;
        it              = blank_item(REQ_START);
        it.sel_len      = SEL_LEN_W'(sel_len);
        it.path_len     = PATH_LEN_W'(path_len);
        it.anchor_start = bol;
        it.anchor_end   = eol;
        return it;
    endfunction

    // Walks the path from the front and the selector from the back, summing one UQ16.16
    // term per atom of each consumed selector entry.
    function automatic match_result_t walk_score(input int unsigned sel_len,
                                                 input int unsigned path_len,
                                                 input bit bol, input bit eol_in);
        int unsigned     i;
        int unsigned     j;
        int unsigned     power;
        int unsigned     p;
        int unsigned     s;
        int unsigned     k;
        int              e;
        bit              eol;
        longint unsigned acc;
        match_result_t   res;
        i     = path_len;
        j     = sel_len;
        power = 0;
        acc   = 0;
        eol   = eol_in;
        while (j != 0 && j <= i)
        begin
            p = path_len - i;
            s = j - 1;
            power += path_atoms_img[PATH_IW'(p)];
            if (sel_bits_img[SEL_IW'(s)]
                == (path_bits_img[PATH_IW'(p)] & sel_mask_img[SEL_IW'(s)]))
            begin
                for (k = 0; k < sel_atoms_img[SEL_IW'(s)]; k++)
                begin
                    e = int'(k) - int'(power);
                    // Terms finer than the fraction are dropped, not rounded.
                    if (e >= -FRAC_BITS)
                    begin
                        acc += 64'd1 << (e + FRAC_BITS);
                        if (acc > SCORE_CEIL)
                            acc = SCORE_CEIL;
                    end
                end
                j--;
            end
            i--;
            // The end anchor only looks at the first step.
            if (eol)
            begin
                if (j == sel_len)
                    break;
                eol = 1'b0;
            end
            if (bol && j == 0 && i != 0)
            begin
                res.matched = 1'b0;
                res.score   = '0;
                return res;
            end
        end
        res.matched = (j == 0);
        res.score   = (j == 0) ? acc[SCORE_W-1:0] : '0;
        return res;
    endfunction

    // Called at the edge where a request transfer completes.
    function automatic void apply_item(input mspm_item_t it);
        int unsigned sl;
        int unsigned pl;
        case (it.kind)
            REQ_LOAD_SEL:
                if (it.slot < SEL_SLOTS)
                begin
                    sel_bits_img[SEL_IW'(it.slot)]  = it.bits;
                    sel_mask_img[SEL_IW'(it.slot)]  = it.mask;
                    sel_atoms_img[SEL_IW'(it.slot)] = it.atoms;
                    accepted_items++;
                end
            REQ_LOAD_PATH:
                if (it.slot < PATH_SLOTS)
                begin
                    path_bits_img[PATH_IW'(it.slot)]  = it.bits;
                    path_atoms_img[PATH_IW'(it.slot)] = it.atoms;
                    accepted_items++;
                end
            REQ_START:
            begin
                sl = (it.sel_len > SEL_SLOTS) ? SEL_SLOTS : it.sel_len;
                pl = (it.path_len > PATH_SLOTS) ? PATH_SLOTS : it.path_len;
                pending_matches.push_back(walk_score(sl, pl, it.anchor_start, it.anchor_end));
                accepted_items++;
            end
            default:
                ;
        endcase
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input mspm_item_t it);
        int unsigned gap;
        gap = source_steady ? 0 : pick_gap();
        repeat (gap) @(negedge clk);
        req_ch.req_type     = it.kind;
        req_ch.slot         = it.slot;
        req_ch.scope_bits   = it.bits;
        req_ch.scope_mask   = it.mask;
        req_ch.atom_count   = it.atoms;
        req_ch.sel_length   = it.sel_len;
        req_ch.path_length  = it.path_len;
        req_ch.anchor_start = it.anchor_start;
        req_ch.anchor_end   = it.anchor_end;
        req_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_item(it);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_matches.size() != 0)
            @(negedge clk);
    endtask

    // Every entry is written first, so no walk can ever read an unloaded entry.
    task automatic test_store_fill();
        int unsigned n;
        for (n = 0; n < PATH_SLOTS; n++)
        begin
            if (n < SEL_SLOTS)
                send_item(make_sel_load(n, rand_word(), pick_mask(), pick_atoms()));
            send_item(make_path_load(n, rand_word(), pick_atoms()));
        end
    endtask

    task automatic test_special_cases();
        int unsigned n;
        // Zero-mask selectors with the largest atom count match anything; with zero
        // path atoms the terms are large enough to saturate the score.
        for (n = 0; n < 3; n++)
            send_item(make_sel_load(n, '0, '0, 4'd15));
        send_item(make_path_load(0, '1, 4'd0));
        send_item(make_path_load(1, '0, 4'd0));
        send_item(make_path_load(2, rand_word(), 4'd0));
        send_item(make_start(3, 3, 1'b0, 1'b0));
        send_item(make_start(3, 3, 1'b1, 1'b1));
        // One path entry left over: the begin anchor fails, the end anchor holds.
        send_item(make_path_load(3, '1, 4'd15));
        send_item(make_start(3, 4, 1'b1, 1'b0));
        send_item(make_start(3, 4, 1'b0, 1'b1));
        // The last selector entry now misses the first path entry, so the end anchor
        // fails while the unanchored walk skips it and still matches.
        send_item(make_sel_load(2, 64'h0, 64'h1, 4'd2));
        send_item(make_start(3, 4, 1'b0, 1'b1));
        send_item(make_start(3, 4, 1'b0, 1'b0));
        // Empty selector, selector longer than the path, both lengths zero.
        send_item(make_start(0, 4, 1'b1, 1'b1));
        send_item(make_start(4, 2, 1'b0, 1'b0));
        send_item(make_start(0, 0, 1'b0, 1'b0));
        // Field extremes, loads beyond the selector store and the unused request code.
        send_item(make_sel_load(15, '1, '1, 4'd15));
        send_item(make_sel_load(16, rand_word(), rand_word(), pick_atoms()));
        send_item(make_sel_load(31, '1, '1, 4'd15));
        send_item(make_path_load(31, '1, 4'd15));
        send_item(blank_item(REQ_UNUSED));
        // Full lengths, then lengths beyond the stores that must saturate.
        send_item(make_start(16, 32, 1'b0, 1'b0));
        send_item(make_start(31, 63, 1'b1, 1'b1));
    endtask

    // Rewrites part of a path, derives selector entries from it so that most compares
    // can hit, then starts a walk over it.
    task automatic run_walk_scenario();
        int unsigned        plen;
        int unsigned        slen;
        int unsigned        span;
        int unsigned        n;
        int unsigned        p;
        int unsigned        r;
        logic [SCOPE_W-1:0] msk;
        logic [SCOPE_W-1:0] bits;
        r = $urandom_range(0, 99);
        if (r < 80)
            plen = $urandom_range(1, 8);
        else if (r < 95)
            plen = $urandom_range(9, 20);
        else
            plen = $urandom_range(21, PATH_SLOTS);
        slen = $urandom_range(0, (plen < SEL_SLOTS) ? plen : SEL_SLOTS);
        if ($urandom_range(0, 9) == 0)
            slen = (plen < SEL_SLOTS) ? plen + 1 : SEL_SLOTS;
        for (n = 0; n < plen; n++)
            if ($urandom_range(0, 1))
                send_item(make_path_load(n, rand_word(), pick_atoms()));
        span = (plen > slen) ? plen - slen : 0;
        for (n = 0; n < slen; n++)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                // The n-th selector from the back lines up with a path entry at n or later.
                p = n + $urandom_range(0, span);
                if (p >= plen)
                    p = plen - 1;
                msk = pick_mask();
                r   = $urandom_range(0, 99);
                if (r < 80)
                    bits = path_bits_img[PATH_IW'(p)] & msk;
                else if (r < 90)
                    bits = (path_bits_img[PATH_IW'(p)] & msk)
                           ^ (64'd1 << $urandom_range(0, SCOPE_W - 1));
                else
                    bits = rand_word();
                send_item(make_sel_load(slen - 1 - n, bits, msk, pick_atoms()));
            end
        end
        send_item(make_start(slen, plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:
                send_item(blank_item(REQ_UNUSED));
            1:
                send_item(make_sel_load($urandom_range(SEL_SLOTS, 31), rand_word(),
                                        rand_word(), ATOM_W'($urandom_range(0, 15))));
            2:
                send_item(make_path_load($urandom_range(0, PATH_SLOTS - 1), rand_word(),
                                         ATOM_W'($urandom_range(0, 15))));
            default:
                send_item(blank_item(REQ_START));
        endcase
    endtask

    task automatic test_random_walks(input int unsigned quota);
        int unsigned first_count;
        first_count = accepted_items;
        while (accepted_items - first_count < quota)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_walk_scenario();
            if ($urandom_range(0, 29) == 0)
                wait_for_results();
        end
    endtask

    // Neither side idles, so transfers follow each other as fast as the core allows.
    task automatic test_back_to_back(input int unsigned quota);
        source_steady = 1'b1;
        sink_steady   = 1'b1;
        test_random_walks(quota);
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // Result receiver: runs of ready, broken by stalls of random length.
    initial
    begin : result_ready_drive
        int unsigned on_len;
        int unsigned off_len;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = 1'b1;
            on_len = $urandom_range(1, 12);
            repeat (on_len) @(negedge clk);
            off_len = sink_steady ? 0 : pick_gap();
            if (off_len != 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (off_len - 1) @(negedge clk);
            end
        end
    end

    // Each result transfer is compared with the oldest outstanding prediction.
    initial
    begin : result_check
        match_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got matched %0b score %h",
                             $time, rsp_ch.matched, rsp_ch.score);
                    fail_count++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (rsp_ch.matched !== want.matched)
                    begin
                        $display("%0t: matched mismatch: expected %0b, got %0b",
                                 $time, want.matched, rsp_ch.matched);
                        fail_count++;
                    end
                    if (rsp_ch.score !== want.score)
                    begin
                        $display("%0t: score mismatch: expected %h, got %h",
                                 $time, want.score, rsp_ch.score);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOAD_SEL;
        req_ch.slot         = '0;
        req_ch.scope_bits   = '0;
        req_ch.scope_mask   = '0;
        req_ch.atom_count   = '0;
        req_ch.sel_length   = '0;
        req_ch.path_length  = '0;
        req_ch.anchor_start = 1'b0;
        req_ch.anchor_end   = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_store_fill();
        test_special_cases();
        // Hold the sender until every outstanding result has been taken.
        wait_for_results();
        test_random_walks(600);
        test_back_to_back(150);
        wait_for_results();
        test_random_walks(600);

        wait_for_results();
        repeat (64) @(posedge clk);
        if (fail_count == 0)
            $display("masked_scope_path_matcher_core verification clean");
        else
            $display("masked_scope_path_matcher_core verification failed");
        $finish;
    end

endmodule
